### sv/arfc_pkg.sv
// Shared types, register map and CRC helper for the ADC reply frame checker.
// No dependencies; imported by every module of the block.
package arfc_pkg;

    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        REG_STATUS_ENABLE   = 3'd0,
        REG_CHECK_MODE      = 3'd1,
        REG_WHICH_CONVERTER = 3'd2,
        REG_CHECKSUM_OFFSET = 3'd3,
        REG_CRC_POLY_LOW    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_SUM  = 2'd1,
        CHK_CRC  = 2'd2,
        CHK_RAW  = 2'd3
    } t_check_mode;

    typedef struct packed {
        logic        status_enable;
        t_check_mode check_mode;
        logic        which_converter;
        logic [7:0]  checksum_offset;
        logic [7:0]  crc_poly_low;
    } t_cfg;

    // what a reply byte is, decided by its place in the frame
    typedef enum logic [1:0] {
        K_STATUS = 2'd0,
        K_DATA   = 2'd1,
        K_PAD    = 2'd2,
        K_CHECK  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        t_kind      kind;
        logic       first;   // first byte of a frame: clear the running state
        logic       done;    // last byte: emit a result
    } t_cmd;

    localparam logic [7:0] CFG_OFFSET_RST = 8'd155;
    localparam logic [7:0] CFG_POLY_RST   = 8'd7;
    localparam logic [7:0] DIFF_MINUS_ONE = 8'd255;

    // one byte into a CRC-8, MSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                             input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/arfc_front.sv
// Front end: takes reply bytes, tracks the frame position and tags each word.
// Depends on arfc_pkg.
module arfc_front
    import arfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [2:0] p_eff;
    logic [2:0] d;
    logic       accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_q_push   = accept;

    assign p_eff = i_frame_start ? 3'd0 : r_pos;
    assign d     = p_eff - {2'b00, i_cfg.status_enable};

    always_comb begin
        o_q_cmd.rx_byte = i_rx_byte;
        o_q_cmd.first   = (p_eff == 3'd0);
        o_q_cmd.done    = 1'b0;
        priority if (i_cfg.status_enable && p_eff == 3'd0) begin
            o_q_cmd.kind = K_STATUS;
        end else if (!d[2]) begin
            o_q_cmd.kind = (i_cfg.which_converter && d[1:0] == 2'd3) ? K_PAD : K_DATA;
            o_q_cmd.done = (d[1:0] == 2'd3) && (i_cfg.check_mode == CHK_NONE);
        end else begin
            // check slot, or a byte past the end of the frame
            o_q_cmd.kind = K_CHECK;
            o_q_cmd.done = 1'b1;
        end
    end

    assign n_pos = o_q_cmd.done ? 3'd0 : p_eff + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

### sv/arfc_queue.sv
// Small flop-based queue of tagged words between front and back end.
// Depends on arfc_pkg.
module arfc_queue
    import arfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### sv/arfc_back.sv
// Back end: folds tagged words into value, sum and CRC; registers the result.
// Depends on arfc_pkg.
module arfc_back
    import arfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_reading,
    output logic [7:0]  o_status_byte,
    output logic        o_check_ok
);

    logic [31:0] r_acc;
    logic [7:0]  r_status;
    logic [7:0]  r_sum;
    logic [7:0]  r_crc;
    logic [31:0] n_acc;
    logic [7:0]  n_status;
    logic [7:0]  n_sum;
    logic [7:0]  n_crc;
    logic [31:0] base_acc;
    logic [7:0]  base_status;
    logic [7:0]  base_sum;
    logic [7:0]  base_crc;
    logic [7:0]  diff;
    logic        ok;
    logic        r_out_valid;
    logic [31:0] r_reading;
    logic [7:0]  r_status_byte;
    logic        r_check_ok;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_out_ready);

    assign base_acc    = i_q_cmd.first ? 32'd0 : r_acc;
    assign base_status = i_q_cmd.first ? 8'd0  : r_status;
    assign base_sum    = i_q_cmd.first ? 8'd0  : r_sum;
    assign base_crc    = i_q_cmd.first ? 8'd0  : r_crc;

    assign diff = base_sum + i_cfg.checksum_offset - i_q_cmd.rx_byte;

    always_comb begin
        n_acc    = base_acc;
        n_status = base_status;
        n_sum    = base_sum;
        n_crc    = base_crc;
        ok       = 1'b1;
        unique case (i_q_cmd.kind)
            K_STATUS: begin
                n_status = i_q_cmd.rx_byte;
            end
            K_DATA: begin
                n_acc = {base_acc[23:0], i_q_cmd.rx_byte};
                n_sum = base_sum + i_q_cmd.rx_byte;
                n_crc = crc8_feed(base_crc, i_q_cmd.rx_byte, i_cfg.crc_poly_low);
            end
            K_PAD: begin
            end
            K_CHECK: begin
                unique case (i_cfg.check_mode)
                    CHK_SUM:  ok = (diff == 8'd0) || (diff == 8'd1) ||
                                   (diff == DIFF_MINUS_ONE);
                    CHK_CRC:  ok = (base_crc == i_q_cmd.rx_byte);
                    CHK_NONE,
                    CHK_RAW:  ok = 1'b1;
                    default:  ok = 1'b1;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_acc    <= n_acc;
            r_status <= n_status;
            r_sum    <= n_sum;
            r_crc    <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && i_q_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_cmd.done) begin
            r_reading     <= i_cfg.which_converter ? {8'd0, n_acc[23:0]} : n_acc;
            r_status_byte <= i_cfg.status_enable ? n_status : 8'd0;
            r_check_ok    <= ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_reading     = r_reading;
    assign o_status_byte = r_status_byte;
    assign o_check_ok    = r_check_ok;

endmodule

### sv/adc_readout_frame_checker.sv
// Top level of the ADC reply frame checker: register file plus front/queue/back.
// Depends on arfc_pkg, arfc_front, arfc_queue, arfc_back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_rx_byte, i_frame_start
//  out     | output    | o_out_valid / i_out_ready| o_reading, o_status_byte, o_check_ok
//  apb     | input     | psel, penable, pready    | paddr, pwdata, pwrite, prdata
//
// One byte per cycle sustained while the queue is not full; a closing byte is written
// into the queue, then folded by the back end into the output register.
// The front end stalls only when the queue is full; the queue drains one word a
// cycle while the output register is empty or being taken.
// Synchronous active-low reset clears the frame position, queue and output valid;
// the first byte after reset starts a frame.
module adc_readout_frame_checker
    import arfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_reading,
    output logic [7:0]           o_status_byte,
    output logic                 o_check_ok,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    t_cfg        r_cfg;
    t_reg_idx    reg_idx;
    logic        cfg_wr;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    t_cmd        q_in;
    t_cmd        q_out;
    logic [31:0] reading;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_enable   <= 1'b1;
            r_cfg.check_mode      <= CHK_SUM;
            r_cfg.which_converter <= 1'b0;
            r_cfg.checksum_offset <= CFG_OFFSET_RST;
            r_cfg.crc_poly_low    <= CFG_POLY_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_STATUS_ENABLE:   r_cfg.status_enable   <= pwdata[0];
                REG_CHECK_MODE:      r_cfg.check_mode      <= t_check_mode'(pwdata[1:0]);
                REG_WHICH_CONVERTER: r_cfg.which_converter <= pwdata[0];
                REG_CHECKSUM_OFFSET: r_cfg.checksum_offset <= pwdata[7:0];
                REG_CRC_POLY_LOW:    r_cfg.crc_poly_low    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STATUS_ENABLE:   prdata = {31'd0, r_cfg.status_enable};
            REG_CHECK_MODE:      prdata = {30'd0, r_cfg.check_mode};
            REG_WHICH_CONVERTER: prdata = {31'd0, r_cfg.which_converter};
            REG_CHECKSUM_OFFSET: prdata = {24'd0, r_cfg.checksum_offset};
            REG_CRC_POLY_LOW:    prdata = {24'd0, r_cfg.crc_poly_low};
            default:             prdata = '0;
        endcase
    end

    arfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in)
    );

    arfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    arfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reading     (reading),
        .o_status_byte (o_status_byte),
        .o_check_ok    (o_check_ok)
    );

    assign o_reading = signed'(reading);

endmodule

### dv/testbench.sv
// Self-checking bench for adc_readout_frame_checker: byte driver, result monitor, APB writes.
// Tracks frames with its own copy of the registers; depends on arfc_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
    import arfc_pkg::*;

    localparam int RAND_ITEMS    = 1350;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] reading;
        logic [7:0]         status_byte;
        logic               check_ok;
    } t_frame_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            rx_byte = 8'h00;
    logic                  frame_start = 1'b0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    logic signed [31:0]    o_reading;
    logic [7:0]            o_status_byte;
    logic                  o_check_ok;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    t_in_word      pending [$];
    t_frame_result frames_due [$];

    // register copy and frame tracking state
    t_cfg       cfg_shadow = {1'b1, CHK_SUM, 1'b0, CFG_OFFSET_RST, CFG_POLY_RST};
    logic [2:0] frm_pos = '0;
    logic [31:0] frm_acc = '0;
    logic [7:0] frm_status = '0;
    logic [7:0] frm_sum = '0;
    logic [7:0] frm_crc = '0;

    int unsigned in_gap = 0;
    int unsigned out_hold = 0;
    bit          in_quiet = 1'b0;
    bit          out_quiet = 1'b0;
    int          fail_count = 0;
    int          items_queued = 0;
    int          bytes_in = 0;
    int          frames_checked = 0;
    int          frames_ok = 0;
    int          reg_writes = 0;
    int          cycles = 0;

    adc_readout_frame_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (rx_byte),
        .i_frame_start (frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_reading     (o_reading),
        .o_status_byte (o_status_byte),
        .o_check_ok    (o_check_ok),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // CRC-8, bit at a time, MSB first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r = {r[6:0], 1'b0} ^ (fb ? poly : 8'h00);
        end
        return r;
    endfunction

    function automatic int unsigned pick_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // distance of the check byte from the correct one; 0, 1 and -1 pass a checksum
    function automatic logic [7:0] pick_err();
        case ($urandom_range(0, 5))
            0, 1: return 8'h00;
            2: return 8'h01;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // classify one accepted byte by the current registers; queue a result on the last byte
    task automatic follow_byte(input logic [7:0] b, input logic start);
        logic [2:0]    pos;
        logic [2:0]    slot;
        logic [7:0]    diff;
        logic          done;
        logic          ok;
        t_frame_result r;
        done = 1'b0;
        ok = 1'b1;
        if (start) frm_pos = '0;
        pos = frm_pos;
        if (pos == 0) begin
            frm_acc = '0;
            frm_status = '0;
            frm_sum = '0;
            frm_crc = '0;
        end
        if (cfg_shadow.status_enable && pos == 0) begin
            frm_status = b;
        end else begin
            slot = pos - 3'(cfg_shadow.status_enable);
            if (slot < 4) begin
                // pad byte of the second converter is dropped
                if (!(cfg_shadow.which_converter && slot == 3)) begin
                    frm_acc = {frm_acc[23:0], b};
                    frm_sum = frm_sum + b;
                    frm_crc = crc_step(frm_crc, b, cfg_shadow.crc_poly_low);
                end
                if (slot == 3 && cfg_shadow.check_mode == CHK_NONE) done = 1'b1;
            end else begin
                // check slot, or a byte past the end after a register change
                done = 1'b1;
                if (cfg_shadow.check_mode == CHK_SUM) begin
                    diff = frm_sum + cfg_shadow.checksum_offset - b;
                    ok = (diff == 8'h00 || diff == 8'h01 || diff == DIFF_MINUS_ONE);
                end else if (cfg_shadow.check_mode == CHK_CRC) begin
                    ok = (frm_crc == b);
                end
            end
        end
        if (done) begin
            frm_pos = '0;
            r.reading = cfg_shadow.which_converter ? {8'h00, frm_acc[23:0]} : frm_acc;
            r.status_byte = cfg_shadow.status_enable ? frm_status : 8'h00;
            r.check_ok = ok;
            frames_due.push_back(r);
        end else begin
            frm_pos = pos + 3'd1;
        end
    endtask

    always @(posedge i_clk) begin : drive_bytes
        bit       took;
        t_in_word w;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            took = in_valid && o_in_ready;
            if (took) begin
                follow_byte(rx_byte, frame_start);
                bytes_in++;
            end
            if (!in_valid || took) begin
                if (in_gap != 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    w = pending.pop_front();
                    rx_byte <= w.data;
                    frame_start <= w.start;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 49) == 0) in_quiet = !in_quiet;
                    in_gap <= pick_wait(in_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_frame_result want;
        int unsigned   w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_hold <= 0;
        end else if (o_out_valid && out_ready) begin
            if (frames_due.size() == 0) begin
                fail_count++;
                $error("result word with no frame pending");
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                if (o_check_ok) frames_ok++;
                if (o_reading !== want.reading) begin
                    fail_count++;
                    $error("reading: expected %h, got %h", want.reading, o_reading);
                end
                if (o_status_byte !== want.status_byte) begin
                    fail_count++;
                    $error("status_byte: expected %h, got %h", want.status_byte, o_status_byte);
                end
                if (o_check_ok !== want.check_ok) begin
                    fail_count++;
                    $error("check_ok: expected %b, got %b", want.check_ok, o_check_ok);
                end
            end
            if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
            w = pick_wait(out_quiet);
            out_hold <= w;
            out_ready <= (w == 0);
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            out_ready <= (out_hold == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic push_item(input logic [7:0] b, input logic start);
        t_in_word w;
        w.data = b;
        w.start = start;
        pending.push_back(w);
        items_queued++;
    endtask

    // queue the first `keep` bytes of a frame laid out for the current registers
    task automatic build_frame(input int keep, input bit mark, input logic [31:0] word,
                               input logic [7:0] stat, input logic [7:0] err);
        logic [7:0] seq [$];
        logic [7:0] sum;
        logic [7:0] crc;
        logic [7:0] b;
        sum = '0;
        crc = '0;
        if (cfg_shadow.status_enable) seq.push_back(stat);
        for (int k = 0; k < 4; k++) begin
            b = word[31 - 8*k -: 8];
            seq.push_back(b);
            if (!(cfg_shadow.which_converter && k == 3)) begin
                sum = sum + b;
                crc = crc_step(crc, b, cfg_shadow.crc_poly_low);
            end
        end
        if (cfg_shadow.check_mode == CHK_SUM) begin
            b = sum + cfg_shadow.checksum_offset - err;
            seq.push_back(b);
        end else if (cfg_shadow.check_mode != CHK_NONE) begin
            seq.push_back(crc ^ err);
        end
        for (int k = 0; k < seq.size() && k < keep; k++) begin
            push_item(seq[k], mark && k == 0);
        end
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STATUS_ENABLE:   cfg_shadow.status_enable = val[0];
            REG_CHECK_MODE:      cfg_shadow.check_mode = t_check_mode'(val[1:0]);
            REG_WHICH_CONVERTER: cfg_shadow.which_converter = val[0];
            REG_CHECKSUM_OFFSET: cfg_shadow.checksum_offset = val[7:0];
            REG_CRC_POLY_LOW:    cfg_shadow.crc_poly_low = val[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // all bytes taken, all results in, then let a partial frame settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending.size() != 0 || in_valid || frames_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : run_stimulus
        int  rand_start;
        int  nfr;
        int  n;
        bit  aligned;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: status, checksum, main converter; data near negative full scale
        build_frame(8, 1'b1, 32'h8000_0001, 8'hA5, 8'h00);
        // no start mark after a completed frame; check two off fails
        build_frame(8, 1'b0, 32'hFFFF_FFFF, 8'h00, 8'h02);
        wait_idle();
        reg_write(REG_STATUS_ENABLE, 32'd0);
        reg_write(REG_CHECK_MODE, 32'(CHK_CRC));
        reg_write(REG_WHICH_CONVERTER, 32'd1);
        // frame cut short and restarted by a start mark, then a CRC frame with pad
        build_frame(2, 1'b1, 32'h0000_00FF, 8'h00, 8'h00);
        build_frame(8, 1'b1, 32'h7FFF_FF5A, 8'h00, 8'h00);
        wait_idle();
        reg_write(REG_CHECK_MODE, 32'(CHK_SUM));
        reg_write(REG_WHICH_CONVERTER, 32'd0);
        // four data bytes, then the check byte is dropped: next byte lies past the end
        build_frame(4, 1'b1, 32'h0102_0304, 8'h00, 8'h00);
        wait_idle();
        reg_write(REG_CHECK_MODE, 32'(CHK_NONE));
        push_item(8'h55, 1'b0);
        // status turned on mid-frame: no status byte was ever captured
        build_frame(2, 1'b1, 32'hFF00_0000, 8'h00, 8'h00);
        wait_idle();
        reg_write(REG_STATUS_ENABLE, 32'd1);
        reg_write(REG_CHECK_MODE, 32'(CHK_RAW));
        for (int k = 0; k < 4; k++) push_item(pick_byte(), 1'b0);

        rand_start = items_queued;
        aligned = 1'b1;
        while (items_queued - rand_start < RAND_ITEMS) begin
            wait_idle();
            reg_write(REG_STATUS_ENABLE, $urandom_range(0, 1));
            reg_write(REG_CHECK_MODE, $urandom_range(0, 3));
            reg_write(REG_WHICH_CONVERTER, $urandom_range(0, 1));
            reg_write(REG_CHECKSUM_OFFSET, 32'(pick_byte()));
            reg_write(REG_CRC_POLY_LOW, 32'(pick_byte()));
            nfr = $urandom_range(4, 16);
            for (int f = 0; f < nfr; f++) begin
                case ($urandom_range(0, 9))
                    8: begin
                        build_frame($urandom_range(1, 4), 1'b1,
                                    {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                                    pick_byte(), pick_err());
                        aligned = 1'b0;
                    end
                    9: begin
                        n = $urandom_range(1, 6);
                        for (int k = 0; k < n; k++) begin
                            push_item(pick_byte(), 1'($urandom_range(0, 1)));
                        end
                        aligned = 1'b0;
                    end
                    default: begin
                        build_frame(8, !aligned || $urandom_range(0, 3) != 0,
                                    {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                                    pick_byte(), pick_err());
                        aligned = 1'b1;
                    end
                endcase
            end
            // sometimes carry an open frame across the register change
            if ($urandom_range(0, 2) == 0) begin
                build_frame($urandom_range(1, 4), 1'b1,
                            {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                            pick_byte(), pick_err());
                aligned = 1'b0;
            end
        end

        wait_idle();
        $display("Sent %0d bytes over %0d register writes; %0d frames checked, %0d passing.",
                 bytes_in, reg_writes, frames_checked, frames_ok);
        if (fail_count == 0 && frames_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : cycle_guard
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

endmodule
